// ===== rtl/jlsr_pkg.sv =====
// Shared constants and types of the jerk-limited speed ramp.
`timescale 1ns / 1ps
package jlsr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int JERK_W    = 31;
   localparam int CSR_IDX_W = 2;

   // shared multiplier: 17 x 17 digits, operands of two digits each
   localparam int DIG_W  = 17;
   localparam int OPD_W  = 2 * DIG_W;
   localparam int PROD_W = 2 * DIG_W;
   localparam int ACC_W  = 70;
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] MAC_LAST = STEP_W'(8);

   localparam logic [JERK_W-1:0]        JERK_RESET      = JERK_W'(10 << FRAC_BITS);
   localparam logic signed [DATA_W-1:0] MAX_ACCEL_RESET = DATA_W'(10 << FRAC_BITS);
   localparam logic signed [DATA_W-1:0] MIN_ACCEL_RESET = -DATA_W'(10 << FRAC_BITS);

   localparam logic CMD_STEP = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_JERK  = 2'd0,
      CSR_MAX_ACCEL = 2'd1,
      CSR_MIN_ACCEL = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MAC,
      ST_UPDATE,
      ST_SUM,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/jlsr_req_if.sv =====
// Request channel of the speed ramp: command, setpoint and preset acceleration.
`timescale 1ns / 1ps
interface jlsr_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [31:0] setpoint_speed;
   logic signed [31:0] preset_accel;

   modport source (output valid, output command, output setpoint_speed,
                   output preset_accel, input ready);
   modport sink   (input valid, input command, input setpoint_speed,
                   input preset_accel, output ready);
endinterface

// ===== rtl/jlsr_rsp_if.sv =====
// Response channel of the speed ramp: ramped speed and settled flag.
`timescale 1ns / 1ps
interface jlsr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] speed_out;
   logic               settled;

   modport source (output valid, output speed_out, output settled, input ready);
   modport sink   (input valid, input speed_out, input settled, output ready);
endinterface

// ===== rtl/jerk_limited_speed_ramp.sv =====
// Sequence: a ramp step runs PREP, MAC, UPDATE, SUM and DONE from accept to rsp valid;
//   an on-target settle skips MAC; load or bypass runs PREP then DONE.
// Flow: one item at a time; req ready stays low from accept until DONE hands the result
//   to the rsp slot, waiting while the slot is busy; the 17x17 multiplier, used for eight
//   partial products of the braking test, sets the length of a ramp step.
// Reset (synchronous, active high): speed and acceleration clear to zero, jerk and upper
//   acceleration limit return to 10.0, lower limit to -10.0, rsp holds no item.
`timescale 1ns / 1ps
module jerk_limited_speed_ramp (
   input  logic                                clock,
   input  logic                                reset,
   jlsr_req_if.sink                            req_bus,
   jlsr_rsp_if.source                          rsp_bus,
   input  logic                                csr_wr_en,
   input  logic [jlsr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [jlsr_pkg::DATA_W-1:0]         csr_wdata
);
   import jlsr_pkg::*;

   // ---------------------------------------------------------------- registers
   state_type state_ff, state_in;

   logic [JERK_W-1:0]        jerk_ff;
   logic signed [DATA_W-1:0] max_acc_ff, min_acc_ff;

   logic signed [DATA_W-1:0] speed_ff, speed_in;
   logic signed [DATA_W-1:0] accel_ff, accel_in;

   // captured request
   logic                     cmd_ff, cmd_in;
   logic signed [DATA_W-1:0] setp_ff, setp_in;
   logic signed [DATA_W-1:0] preset_ff, preset_in;

   // braking test operands and flags
   logic [OPD_W-1:0]         twoj_ff, twoj_in;
   logic [OPD_W-1:0]         absdiff_ff, absdiff_in;
   logic [OPD_W-1:0]         n_ff, n_in;
   logic                     diff_neg_ff, diff_neg_in;
   logic                     settle_ff, settle_in;

   // shared multiply-accumulate unit
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic                     tag_sub_ff, tag_sub_in;
   logic [1:0]               tag_sh_ff, tag_sh_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;

   // finished result and output slot
   logic signed [DATA_W-1:0] res_speed_ff, res_speed_in;
   logic                     res_settled_ff, res_settled_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic                     rsp_settled_ff, rsp_settled_in;

   // ---------------------------------------------------------------- helpers
   logic                     req_fire;
   logic                     slot_free;
   logic [DATA_W-1:0]        absacc;
   logic signed [DATA_W:0]   diff;
   logic [DATA_W:0]          absdiff_w;
   logic [OPD_W-1:0]         opd_a, opd_b;
   logic [DIG_W-1:0]         dig_a, dig_b;
   logic [ACC_W-1:0]         pp_shifted;
   logic                     push;
   logic                     jerk_neg;
   logic signed [DATA_W+1:0] base_acc, jerk_val, acc_sum, acc_clamped;
   logic signed [DATA_W:0]   spd_sum;
   logic signed [DATA_W-1:0] spd_sat;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.speed_out = rsp_speed_ff;
   assign rsp_bus.settled   = rsp_settled_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         jerk_ff    <= JERK_RESET;
         max_acc_ff <= MAX_ACCEL_RESET;
         min_acc_ff <= MIN_ACCEL_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_JERK:  jerk_ff    <= csr_wdata[JERK_W-1:0];
            CSR_MAX_ACCEL: max_acc_ff <= csr_wdata;
            CSR_MIN_ACCEL: min_acc_ff <= csr_wdata;
            default: ;     // unlisted index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------- arithmetic
   // Magnitudes for the braking test. |accel| of the most negative value
   // still fits as an unsigned 32-bit number.
   always_comb begin
      absacc    = accel_ff[DATA_W-1] ? DATA_W'(-accel_ff) : DATA_W'(accel_ff);
      diff      = (DATA_W+1)'(setp_ff) - (DATA_W+1)'(speed_ff);
      absdiff_w = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
   end

   // Partial product select. Steps 0..3 form 2J*|diff| (added), steps 4..7
   // form N*N (subtracted); bits 1 and 0 pick the digit of each operand.
   always_comb begin
      opd_a = step_ff[2] ? n_ff : twoj_ff;
      opd_b = step_ff[2] ? n_ff : absdiff_ff;
      dig_a = step_ff[1] ? opd_a[OPD_W-1:DIG_W] : opd_a[DIG_W-1:0];
      dig_b = step_ff[0] ? opd_b[OPD_W-1:DIG_W] : opd_b[DIG_W-1:0];
      unique case (tag_sh_ff)
         2'd1:    pp_shifted = ACC_W'(prod_ff) << DIG_W;
         2'd2:    pp_shifted = ACC_W'(prod_ff) << (2 * DIG_W);
         default: pp_shifted = ACC_W'(prod_ff);
      endcase
   end

   // Accumulator holds 2J*|diff| - N*N; braking when it is not negative.
   assign push = !acc_ff[ACC_W-1];

   // Jerk direction, acceleration clamp and saturating speed add.
   always_comb begin
      if (diff_neg_ff) begin
         jerk_neg = (accel_ff > 0) || push;
      end else begin
         jerk_neg = !((accel_ff < 0) || push);
      end
      base_acc = settle_ff ? '0 : (DATA_W+2)'(accel_ff);
      if (settle_ff) begin
         jerk_val = '0;
      end else if (jerk_neg) begin
         jerk_val = -(DATA_W+2)'($signed({1'b0, jerk_ff}));
      end else begin
         jerk_val = (DATA_W+2)'($signed({1'b0, jerk_ff}));
      end
      acc_sum     = base_acc + jerk_val;
      acc_clamped = acc_sum;
      // max clamp first, then min clamp: min wins when the limits cross
      if (acc_clamped > (DATA_W+2)'(max_acc_ff)) begin
         acc_clamped = (DATA_W+2)'(max_acc_ff);
      end
      if (acc_clamped < (DATA_W+2)'(min_acc_ff)) begin
         acc_clamped = (DATA_W+2)'(min_acc_ff);
      end

      spd_sum = (DATA_W+1)'(speed_ff) + (DATA_W+1)'(accel_ff);
      if (spd_sum[DATA_W] != spd_sum[DATA_W-1]) begin
         spd_sat = spd_sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                   : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         spd_sat = spd_sum[DATA_W-1:0];
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      speed_in       = speed_ff;
      accel_in       = accel_ff;
      cmd_in         = cmd_ff;
      setp_in        = setp_ff;
      preset_in      = preset_ff;
      twoj_in        = twoj_ff;
      absdiff_in     = absdiff_ff;
      n_in           = n_ff;
      diff_neg_in    = diff_neg_ff;
      settle_in      = settle_ff;
      step_in        = step_ff;
      prod_in        = prod_ff;
      tag_sub_in     = tag_sub_ff;
      tag_sh_in      = tag_sh_ff;
      acc_in         = acc_ff;
      res_speed_in   = res_speed_ff;
      res_settled_in = res_settled_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_speed_in   = rsp_speed_ff;
      rsp_settled_in = rsp_settled_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // capture the item
            if (req_fire) begin
               cmd_in    = req_bus.command;
               setp_in   = req_bus.setpoint_speed;
               preset_in = req_bus.preset_accel;
               state_in  = ST_PREP;
            end
         end

         ST_PREP: begin
            if (cmd_ff == CMD_LOAD) begin
               // preset the state, report the loaded speed as not settled
               speed_in       = setp_ff;
               accel_in       = preset_ff;
               res_speed_in   = setp_ff;
               res_settled_in = 1'b0;
               state_in       = ST_DONE;
            end else if (jerk_ff == '0) begin
               // bypass: pass the setpoint, leave the state alone
               res_speed_in   = setp_ff;
               res_settled_in = 1'b1;
               state_in       = ST_DONE;
            end else begin
               twoj_in     = OPD_W'({jerk_ff, 1'b0});
               absdiff_in  = OPD_W'(absdiff_w);
               n_in        = OPD_W'(absacc) + OPD_W'({jerk_ff, 1'b0});
               diff_neg_in = diff[DATA_W];
               settle_in   = (absdiff_w == '0) && (absacc <= DATA_W'(jerk_ff));
               acc_in      = '0;
               step_in     = '0;
               // on the settle path the braking test is not needed
               state_in    = ((absdiff_w == '0) && (absacc <= DATA_W'(jerk_ff)))
                             ? ST_UPDATE : ST_MAC;
            end
         end

         ST_MAC: begin
            // multiply one digit pair, accumulate the previous product
            if (step_ff != MAC_LAST) begin
               prod_in    = PROD_W'(dig_a) * PROD_W'(dig_b);
               tag_sub_in = step_ff[2];
               tag_sh_in  = 2'(step_ff[1]) + 2'(step_ff[0]);
            end
            if (step_ff != '0) begin
               acc_in = tag_sub_ff ? acc_ff - pp_shifted : acc_ff + pp_shifted;
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == MAC_LAST) begin
               state_in = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            // new acceleration; the settle path lands the speed on the setpoint
            accel_in = acc_clamped[DATA_W-1:0];
            if (settle_ff) begin
               speed_in = setp_ff;
            end
            state_in = ST_SUM;
         end

         ST_SUM: begin
            speed_in       = spd_sat;
            res_speed_in   = spd_sat;
            res_settled_in = settle_ff;
            state_in       = ST_DONE;
         end

         ST_DONE: begin
            // hand the result over once the output slot is free
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_speed_in   = res_speed_ff;
               rsp_settled_in = res_settled_ff;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= '0;
         accel_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         speed_ff     <= speed_in;
         accel_ff     <= accel_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      setp_ff        <= setp_in;
      preset_ff      <= preset_in;
      twoj_ff        <= twoj_in;
      absdiff_ff     <= absdiff_in;
      n_ff           <= n_in;
      diff_neg_ff    <= diff_neg_in;
      settle_ff      <= settle_in;
      prod_ff        <= prod_in;
      tag_sub_ff     <= tag_sub_in;
      tag_sh_ff      <= tag_sh_in;
      acc_ff         <= acc_in;
      res_speed_ff   <= res_speed_in;
      res_settled_ff <= res_settled_in;
      rsp_speed_ff   <= rsp_speed_in;
      rsp_settled_ff <= rsp_settled_in;
   end

   // ---------------------------------------------------------------- checks
   // only one item in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("request taken while an item is in flight");

   // the multiply-accumulate sequence ends after its last step
   a_mac_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC && step_ff == MAC_LAST) |=> state_ff == ST_UPDATE)
      else $error("multiply-accumulate did not finish");

   // step counter stays in range while the shared unit runs
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> step_ff <= MAC_LAST)
      else $error("step counter out of range");

   // updated acceleration respects consistent limits
   a_accel_clamp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && min_acc_ff <= max_acc_ff && !csr_wr_en)
      |=> (accel_ff <= max_acc_ff && accel_ff >= min_acc_ff))
      else $error("acceleration outside its limits");

   // a finished result waits in DONE until the slot is free, never overwrites
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_bus.ready)
      |=> state_ff == ST_DONE)
      else $error("result handed over while slot was busy");

endmodule
